/* hw/rtl/mac_vendor_prefix_lookup_assert.svh */
// Assertion macros for the vendor prefix lookup block.
// Stand-alone header; used by the top level, which supplies clock and reset.
`ifndef MAC_VENDOR_PREFIX_LOOKUP_ASSERT_SVH
`define MAC_VENDOR_PREFIX_LOOKUP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MVPL_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MVPL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/mvpl_pkg.sv */
// Shared types, codes and helper functions for the vendor prefix lookup block.
// No dependencies; imported by every module of the block.
package mvpl_pkg;

  localparam int unsigned KEY_DEPTH_DEF = 65536;
  // Wide enough to hold the largest supported key memory depth itself.
  localparam int unsigned DEPTH_W       = 21;
  localparam int unsigned BOUND_W       = 17;
  localparam int unsigned PTR_W         = BOUND_W + 1;
  localparam int unsigned NUM_BOUNDS    = 6;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned KEY_W         = 36;
  localparam int unsigned MAC_W         = 48;
  localparam int unsigned ENTRY_IDX_W   = 16;
  localparam int unsigned REGION_W      = 3;
  localparam int unsigned LEN_W         = 6;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned IN_TDATA_W    = 104;
  localparam int unsigned OUT_TDATA_W   = 32;

  // Command carried in the input tuser.
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_NONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_MCAST = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_LOCAL = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_MATCH = 2'd3;

  // Regions in search order; REGION_END marks that all have been tried.
  localparam logic [REGION_W-1:0] REGION_MAC36 = 3'd0;
  localparam logic [REGION_W-1:0] REGION_MAC28 = 3'd1;
  localparam logic [REGION_W-1:0] REGION_IAB   = 3'd2;
  localparam logic [REGION_W-1:0] REGION_MAC24 = 3'd3;
  localparam logic [REGION_W-1:0] REGION_CID   = 3'd4;
  localparam logic [REGION_W-1:0] REGION_END   = 3'd5;

  localparam logic [LEN_W-1:0] LEN_36 = 6'd36;
  localparam logic [LEN_W-1:0] LEN_28 = 6'd28;
  localparam logic [LEN_W-1:0] LEN_24 = 6'd24;

  // Addresses starting 00:50:C2 are the only ones searched in the IAB region.
  localparam logic [23:0] IAB_OUI = 24'h0050C2;

  // Region start registers followed by the end register.
  typedef logic [NUM_BOUNDS-1:0][BOUND_W-1:0] bounds_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [LEN_W-1:0]       match_length;
    logic [REGION_W-1:0]    region_hit;
    logic [ENTRY_IDX_W-1:0] record_index;
  } result_t;

  // Handshake status from the search engine to the top level.
  typedef struct packed {
    logic idle;
    logic res_valid;
  } eng_status_t;

  // Prefix length reported for a hit in each region.
  function automatic logic [LEN_W-1:0] region_len(input logic [REGION_W-1:0] region);
    logic [LEN_W-1:0] len;
    case (region)
      REGION_MAC36: len = LEN_36;
      REGION_MAC28: len = LEN_28;
      REGION_IAB:   len = LEN_36;
      REGION_MAC24: len = LEN_24;
      REGION_CID:   len = LEN_24;
      default:      len = '0;
    endcase
    return len;
  endfunction

  // Search key for each region: the address prefix, zero-extended to the key width.
  function automatic logic [KEY_W-1:0] region_key(input logic [REGION_W-1:0] region,
                                                  input logic [MAC_W-1:0] mac);
    logic [KEY_W-1:0] key;
    case (region)
      REGION_MAC36: key = mac[47:12];
      REGION_MAC28: key = {8'd0, mac[47:20]};
      REGION_IAB:   key = mac[47:12];
      REGION_MAC24: key = {12'd0, mac[47:24]};
      REGION_CID:   key = {12'd0, mac[47:24]};
      default:      key = '0;
    endcase
    return key;
  endfunction

endpackage

/* hw/rtl/mac_vendor_prefix_lookup.sv */
// Top level of the vendor prefix lookup: configuration registers, input
// handshake, output register. Depends on mvpl_pkg, mvpl_key_mem, mvpl_search.
// A write word (tuser 0) stores one key. A lookup word (tuser 1) gives one
// result word. Multicast and locally administered addresses go straight to
// the done state. Otherwise each region passes a setup state, and each probe
// a probe state (address) and a wait state (compare of the registered read
// word from the single key memory read port); a region that runs out ends in
// the probe state. There are five regions of up to seventeen probes each.
// One lookup is in flight at a time; the next word is accepted as soon as the
// result is in the output register. The key memory is not cleared: software
// loads all regions before lookups.
`include "mac_vendor_prefix_lookup_assert.svh"

module mac_vendor_prefix_lookup #(
  parameter int unsigned KEY_DEPTH = mvpl_pkg::KEY_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration write port.
  input  logic                             cfg_we_i,
  input  logic [mvpl_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [mvpl_pkg::BOUND_W-1:0]     cfg_data_i,
  // Input stream.
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata, from bit 0: entry_index[15:0], entry_key[35:0], mac_address[47:0], zero fill.
  input  logic [mvpl_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // tuser: command.
  input  logic                             s_axis_tuser,
  // Output stream.
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tdata, from bit 0: status[1:0], match_length[5:0], region_hit[2:0],
  // record_index[15:0], zero fill.
  output logic [mvpl_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import mvpl_pkg::*;

  localparam int unsigned AW = $clog2(KEY_DEPTH);
  localparam logic [DEPTH_W-1:0] DEPTH_LIM = DEPTH_W'(KEY_DEPTH);

  bounds_t            bounds_q;
  logic               out_valid_q, out_valid_d;
  result_t            out_q;
  logic               s_acc, mem_we, start, res_take;
  logic [DEPTH_W-1:0] entry_idx_w;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic [KEY_W-1:0]   mem_rdata;
  eng_status_t        eng_status;
  result_t            eng_res;

  // Region bound registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bounds_q <= '0;
    end else if (cfg_we_i && (cfg_index_i < CFG_IDX_W'(NUM_BOUNDS))) begin
      bounds_q[cfg_index_i] <= cfg_data_i;
    end
  end

  // Input word decode.
  assign s_axis_tready = eng_status.idle;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign entry_idx_w   = DEPTH_W'(s_axis_tdata[15:0]);
  assign mem_we        = s_acc && (s_axis_tuser == CMD_WRITE) && (entry_idx_w < DEPTH_LIM);
  assign start         = s_acc && (s_axis_tuser == CMD_LOOKUP);

  mvpl_key_mem #(
    .KEY_DEPTH (KEY_DEPTH),
    .AW        (AW)
  ) u_key_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_we),
    .wr_addr_i (entry_idx_w[AW-1:0]),
    .wr_data_i (s_axis_tdata[51:16]),
    .rd_en_i   (mem_re),
    .rd_addr_i (mem_raddr),
    .rd_data_o (mem_rdata)
  );

  mvpl_search #(
    .KEY_DEPTH (KEY_DEPTH),
    .AW        (AW)
  ) u_search (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .mac_i      (s_axis_tdata[99:52]),
    .bounds_i   (bounds_q),
    .rd_en_o    (mem_re),
    .rd_addr_o  (mem_raddr),
    .rd_data_i  (mem_rdata),
    .status_o   (eng_status),
    .result_o   (eng_res),
    .res_take_i (res_take)
  );

  // Output register: takes a result whenever the slot is free or being emptied.
  assign res_take    = eng_status.res_valid && (!out_valid_q || m_axis_tready);
  assign out_valid_d = res_take || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= eng_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_q.record_index, out_q.region_hit,
                          out_q.match_length, out_q.status};

  // A lookup keeps the input closed until its result has been handed over.
  `MVPL_ASSERT_NEXT(a_lookup_blocks, clk_i, rst_ni, start, !s_axis_tready, "lookup did not close input")
  // A waiting result is held unchanged until the output slot takes it.
  `MVPL_ASSERT_NEXT(a_result_held, clk_i, rst_ni, eng_status.res_valid && !res_take, eng_status.res_valid && $stable(eng_res), "pending result changed")
  // A match always reports one of the three prefix lengths.
  `MVPL_ASSERT_SAME(a_match_len, clk_i, rst_ni, out_valid_q && (out_q.status == STATUS_MATCH), (out_q.match_length == LEN_36) || (out_q.match_length == LEN_28) || (out_q.match_length == LEN_24), "bad match length")
  // Anything but a match carries zero length, region and index.
  `MVPL_ASSERT_SAME(a_nomatch_zero, clk_i, rst_ni, out_valid_q && (out_q.status != STATUS_MATCH), (out_q.match_length == '0) && (out_q.region_hit == '0) && (out_q.record_index == '0), "non-match fields not zero")

endmodule

/* hw/rtl/mvpl_key_mem.sv */
// Key memory: one write port and one read port with a registered read word.
// Depends on mvpl_pkg for the key width.
module mvpl_key_mem #(
  parameter int unsigned KEY_DEPTH = mvpl_pkg::KEY_DEPTH_DEF,
  parameter int unsigned AW        = $clog2(KEY_DEPTH)
) (
  input  logic                       clk_i,
  input  logic                       wr_en_i,
  input  logic [AW-1:0]              wr_addr_i,
  input  logic [mvpl_pkg::KEY_W-1:0] wr_data_i,
  input  logic                       rd_en_i,
  input  logic [AW-1:0]              rd_addr_i,
  output logic [mvpl_pkg::KEY_W-1:0] rd_data_o
);
  import mvpl_pkg::*;

  logic [KEY_W-1:0] key_mem_q [KEY_DEPTH];
  logic [KEY_W-1:0] rd_data_q;

  // Synchronous write and read; the read word is registered and available in the next cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      key_mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= key_mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* hw/rtl/mvpl_search.sv */
// Search engine: walks the five regions in order until the first hit,
// binary-searching each one through the key memory read port. Depends on mvpl_pkg.
module mvpl_search #(
  parameter int unsigned KEY_DEPTH = mvpl_pkg::KEY_DEPTH_DEF,
  parameter int unsigned AW        = $clog2(KEY_DEPTH)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [mvpl_pkg::MAC_W-1:0] mac_i,
  input  mvpl_pkg::bounds_t          bounds_i,
  output logic                       rd_en_o,
  output logic [AW-1:0]              rd_addr_o,
  input  logic [mvpl_pkg::KEY_W-1:0] rd_data_i,
  output mvpl_pkg::eng_status_t      status_o,
  output mvpl_pkg::result_t          result_o,
  input  logic                       res_take_i
);
  import mvpl_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_PROBE = 3'd2;
  localparam logic [2:0] S_WAIT  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  localparam logic [DEPTH_W-1:0] DEPTH_LIM = DEPTH_W'(KEY_DEPTH);

  logic [2:0]               state_q, state_d;
  logic [REGION_W-1:0]      region_q, region_d;
  logic signed [PTR_W-1:0]  lo_q, lo_d;
  logic signed [PTR_W-1:0]  hi_q, hi_d;
  logic [BOUND_W-1:0]       base_q, base_d;
  logic [BOUND_W-1:0]       mid_q, mid_d;
  logic [MAC_W-1:0]         mac_q, mac_d;
  result_t                  res_q, res_d;

  logic [DEPTH_W-1:0]       begin_w, next_w, end_w, addr_w;
  logic signed [PTR_W-1:0]  span, mid;
  logic [KEY_W-1:0]         key;
  logic                     is_iab;

  // Region bounds: start of this region, end clipped to the memory depth.
  always_comb begin
    begin_w = '0;
    next_w  = '0;
    if (region_q < REGION_END) begin
      begin_w = DEPTH_W'(bounds_i[region_q]);
      next_w  = DEPTH_W'(bounds_i[region_q + 3'd1]);
    end
    end_w = (next_w < DEPTH_LIM) ? next_w : DEPTH_LIM;
  end

  // Probe position and memory address of the current probe.
  assign span   = hi_q - lo_q;
  assign mid    = lo_q + (span >>> 1);
  assign addr_w = DEPTH_W'(base_q) + DEPTH_W'(mid[BOUND_W-1:0]);
  assign key    = region_key(region_q, mac_q);
  assign is_iab = (mac_q[47:24] == IAB_OUI);

  assign rd_en_o   = (state_q == S_PROBE) && (lo_q <= hi_q);
  assign rd_addr_o = addr_w[AW-1:0];

  // Sequencer: setup per region, then read and compare per probe.
  always_comb begin
    state_d  = state_q;
    region_d = region_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    base_d   = base_q;
    mid_d    = mid_q;
    mac_d    = mac_q;
    res_d    = res_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          mac_d    = mac_i;
          region_d = REGION_MAC36;
          res_d    = '0;
          if (mac_i[40]) begin
            res_d.status = STATUS_MCAST;
            state_d      = S_DONE;
          end else if (mac_i[41]) begin
            res_d.status = STATUS_LOCAL;
            state_d      = S_DONE;
          end else begin
            state_d = S_SETUP;
          end
        end
      end
      S_SETUP: begin
        if (region_q >= REGION_END) begin
          state_d = S_DONE;
        end else if ((region_q == REGION_IAB) && !is_iab) begin
          region_d = region_q + 3'd1;
        end else if (begin_w >= end_w) begin
          // Empty or reversed region: skip it.
          region_d = region_q + 3'd1;
        end else begin
          base_d  = begin_w[BOUND_W-1:0];
          lo_d    = '0;
          hi_d    = PTR_W'(end_w) - PTR_W'(begin_w) - PTR_W'(1);
          state_d = S_PROBE;
        end
      end
      S_PROBE: begin
        if (lo_q <= hi_q) begin
          mid_d   = mid[BOUND_W-1:0];
          state_d = S_WAIT;
        end else begin
          region_d = region_q + 3'd1;
          state_d  = S_SETUP;
        end
      end
      S_WAIT: begin
        if (rd_data_i == key) begin
          res_d.status       = STATUS_MATCH;
          res_d.match_length = region_len(region_q);
          res_d.region_hit   = region_q;
          res_d.record_index = mid_q[ENTRY_IDX_W-1:0];
          state_d            = S_DONE;
        end else begin
          if (rd_data_i < key) begin
            lo_d = signed'({1'b0, mid_q}) + PTR_W'(1);
          end else begin
            hi_d = signed'({1'b0, mid_q}) - PTR_W'(1);
          end
          state_d = S_PROBE;
        end
      end
      S_DONE: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state is reset; the rest is payload.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      region_q <= '0;
      lo_q     <= '0;
      hi_q     <= '0;
    end else begin
      state_q  <= state_d;
      region_q <= region_d;
      lo_q     <= lo_d;
      hi_q     <= hi_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    mid_q  <= mid_d;
    mac_q  <= mac_d;
    res_q  <= res_d;
  end

  assign status_o.idle      = (state_q == S_IDLE);
  assign status_o.res_valid = (state_q == S_DONE);
  assign result_o           = res_q;

endmodule

/* test/tb_mac_vendor_prefix_lookup.sv */
// Self-checking testbench for the vendor prefix lookup: loads mostly sorted key regions,
// sends lookup words and compares every result word with a software search.
// Depends on mvpl_pkg and mac_vendor_prefix_lookup.
module tb_mac_vendor_prefix_lookup;
  timeunit 1ns;
  timeprecision 1ps;

  import mvpl_pkg::*;

  localparam int KEY_DEPTH      = KEY_DEPTH_DEF;
  localparam int NUM_REGIONS    = 5;
  localparam int BOUND_MAX      = (1 << BOUND_W) - 1;
  localparam int TOTAL_WORDS    = 1550;
  localparam int SETTLE_CYCLES  = 200;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 4000;

  // Register indexes of the configuration port.
  localparam int REG_START_MAC36 = 0;
  localparam int REG_START_MAC28 = 1;
  localparam int REG_START_IAB   = 2;
  localparam int REG_START_MAC24 = 3;
  localparam int REG_START_CID   = 4;
  localparam int REG_END_ALL     = 5;

  // Prefix length of each region, which is also the width of its keys.
  localparam int PREFIX_BITS [NUM_REGIONS] = '{36, 28, 36, 24, 24};

  // Hand-picked keys for the directed layout: two per region, each region sorted.
  localparam logic [KEY_W-1:0] SEED_KEYS [10] = '{
    36'h0050C2123, 36'hACDE48001,  // 36-bit prefixes
    36'h001B638,   36'hF0F0F0F,    // 28-bit prefixes
    36'h0050C2000, 36'h0050C2FFF,  // IAB
    36'h00000C,    36'hFCFFFF,     // 24-bit prefixes
    36'h001B63,    36'h4C5E0C      // company ids
  };

  // Lookups with every region empty, as left by reset.
  localparam logic [MAC_W-1:0] RESET_PROBES [5] = '{
    48'hFFFFFFFFFFFF, 48'h000000000000, 48'h020000000000,
    48'h030000000000, 48'h0050C2000000
  };

  // Lookups against the directed layout: hits in each region, order of
  // precedence, IAB gating and plain misses.
  localparam logic [MAC_W-1:0] LAYOUT_PROBES [12] = '{
    48'h0050C2123456, 48'hACDE48001FFF, 48'hF0F0F0F12345, 48'h0050C2FFF000,
    48'h0050C2000ABC, 48'h00000C123456, 48'hFCFFFFFFFFFF, 48'h001B634ABCDE,
    48'h001B638ABCDE, 48'h4C5E0C000000, 48'h102030405060, 48'h0050C3000000
  };

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_index_i;
  logic [BOUND_W-1:0]     cfg_data_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // Mirror of the key memory and the region bounds, with the lookups still
  // waiting for their result word.
  class prefix_match_board;
    logic [KEY_W-1:0] key_mirror [KEY_DEPTH];
    int               bound_mirror [NUM_BOUNDS];
    result_t          pending_matches [$];
    int               failures;

    function void set_bound(int index, logic [BOUND_W-1:0] value);
      if (index < NUM_BOUNDS) bound_mirror[index] = int'(value);
    endfunction

    // Binary search of one region, hi inclusive; pos is relative to the region.
    function bit probe_region(int region, logic [KEY_W-1:0] key, output int pos);
      int lo;
      int hi;
      int mid;
      int b;
      int e;
      pos = 0;
      b = bound_mirror[region];
      e = bound_mirror[region + 1];
      if (e > KEY_DEPTH) e = KEY_DEPTH;
      if (b >= e) return 1'b0;
      lo = 0;
      hi = e - b - 1;
      while (lo <= hi) begin
        mid = lo + (hi - lo) / 2;
        if (key_mirror[b + mid] == key) begin
          pos = mid;
          return 1'b1;
        end
        if (key_mirror[b + mid] < key) lo = mid + 1;
        else hi = mid - 1;
      end
      return 1'b0;
    endfunction

    // Expected result of a lookup: address class first, then the first hit.
    function result_t search_prefix_regions(logic [MAC_W-1:0] mac);
      result_t          res;
      logic [KEY_W-1:0] key;
      int               pos;
      res = '0;
      if (mac[40]) begin
        res.status = STATUS_MCAST;
        return res;
      end
      if (mac[41]) begin
        res.status = STATUS_LOCAL;
        return res;
      end
      for (int r = 0; r < NUM_REGIONS; r++) begin
        if (r == int'(REGION_IAB) && mac[47:24] != IAB_OUI) continue;
        key = KEY_W'(mac >> (MAC_W - PREFIX_BITS[r]));
        if (probe_region(r, key, pos)) begin
          res.status       = STATUS_MATCH;
          res.match_length = LEN_W'(PREFIX_BITS[r]);
          res.region_hit   = REGION_W'(r);
          res.record_index = ENTRY_IDX_W'(pos);
          return res;
        end
      end
      return res;
    endfunction

    function void note_word(logic cmd, logic [ENTRY_IDX_W-1:0] index,
                            logic [KEY_W-1:0] key, logic [MAC_W-1:0] mac);
      if (cmd == CMD_WRITE) begin
        if (int'(index) < KEY_DEPTH) key_mirror[index] = key;
      end else begin
        pending_matches.push_back(search_prefix_regions(mac));
      end
    endfunction

    function void check_word(logic [OUT_TDATA_W-1:0] tdata);
      result_t     want;
      int unsigned want_f [4];
      int unsigned got_f [4];
      string       tag [4];
      if (pending_matches.size() == 0) begin
        $display("%0t: result word %h with no lookup pending, expected none", $time, tdata);
        failures++;
        return;
      end
      want = pending_matches.pop_front();
      tag    = '{"status", "match_length", "region_hit", "record_index"};
      want_f = '{want.status, want.match_length, want.region_hit, want.record_index};
      got_f  = '{tdata[1:0], tdata[7:2], tdata[10:8], tdata[26:11]};
      for (int i = 0; i < 4; i++) begin
        if (want_f[i] != got_f[i]) begin
          $display("%0t: %s mismatch, expected %0d actual %0d",
                   $time, tag[i], want_f[i], got_f[i]);
          failures++;
        end
      end
    endfunction
  endclass

  prefix_match_board sb = new();

  int bnd [NUM_BOUNDS];
  int words_sent;
  int hold_requests;
  int tx_run;
  bit tx_steady;

  mac_vendor_prefix_lookup #(
    .KEY_DEPTH(KEY_DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Mostly short pauses, now and then a long one.
  function automatic int idle_len();
    return ($urandom_range(0, 9) == 0) ? int'($urandom_range(8, 40))
                                       : int'($urandom_range(1, 3));
  endfunction

  // Offers one word after an optional pause and returns once it is taken.
  task automatic send_word(input logic cmd, input logic [ENTRY_IDX_W-1:0] index,
                           input logic [KEY_W-1:0] key, input logic [MAC_W-1:0] mac);
    int gap;
    if (tx_run == 0) begin
      tx_steady = ($urandom_range(0, 3) == 0);
      tx_run    = $urandom_range(20, 120);
    end
    tx_run--;
    gap = (!tx_steady && $urandom_range(0, 2) == 0) ? idle_len() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {4'd0, mac, key, index};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_word(cmd, index, key, mac);
    words_sent++;
  endtask

  // Stops offering, waits for every outstanding result, then lets the block settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_matches.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes all bound registers from bnd; with with_spare the spare indexes also get random data.
  task automatic apply_bounds(input bit with_spare);
    int                 last;
    logic [BOUND_W-1:0] value;
    logic [63:0]        fill;
    last = with_spare ? (1 << CFG_IDX_W) - 1 : NUM_BOUNDS - 1;
    for (int i = 0; i <= last; i++) begin
      fill  = rand64();
      value = (i < NUM_BOUNDS) ? BOUND_W'(bnd[i]) : fill[BOUND_W-1:0];
      cfg_we_i    <= 1'b1;
      cfg_index_i <= CFG_IDX_W'(i);
      cfg_data_i  <= value;
      @(posedge clk_i);
      sb.set_bound(i, value);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Picks region bounds: random placement, bottom and top of memory, clipped
  // end, empty and reversed regions. One phase carries a large region.
  task automatic plan_layout(input int phase);
    int sizes [NUM_REGIONS];
    int total;
    int r;
    total = 0;
    for (int i = 0; i < NUM_REGIONS; i++) begin
      sizes[i] = ($urandom_range(0, 5) == 0) ? 0 : int'($urandom_range(1, 12));
      total += sizes[i];
    end
    if (phase == 6) begin
      total += 250 - sizes[REGION_MAC24];
      sizes[REGION_MAC24] = 250;
    end
    case (phase % 5)
      1:       bnd[REG_START_MAC36] = 0;
      2, 3:    bnd[REG_START_MAC36] = KEY_DEPTH - total;
      default: bnd[REG_START_MAC36] = $urandom_range(0, KEY_DEPTH - total);
    endcase
    for (int i = 0; i < NUM_REGIONS; i++) bnd[i + 1] = bnd[i] + sizes[i];
    if (phase % 5 == 3) bnd[REG_END_ALL] = BOUND_MAX;
    if (phase % 5 == 4) begin
      // Push one start onto or past the next bound so that region is skipped.
      r = $urandom_range(REG_START_MAC28, REG_START_CID);
      bnd[r] = bnd[r + 1] + $urandom_range(0, 5);
    end
  endtask

  // Fills every non-empty region with ascending keys whose multicast and local
  // bits are clear; now and then a region gets unsorted random keys instead.
  task automatic load_regions();
    int               b;
    int               e;
    int               w;
    int               low_bits;
    int               step_max;
    longint           lo;
    longint           half;
    bit               iab_like;
    bit               scrambled;
    logic [KEY_W-1:0] top;
    logic [KEY_W-1:0] key;
    logic [63:0]      fill;
    for (int r = 0; r < NUM_REGIONS; r++) begin
      b = bnd[r];
      e = (bnd[r + 1] > KEY_DEPTH) ? KEY_DEPTH : bnd[r + 1];
      if (b >= e) continue;
      w         = PREFIX_BITS[r];
      iab_like  = (r == int'(REGION_IAB)) ||
                  (r == int'(REGION_MAC36) && $urandom_range(0, 7) == 0);
      scrambled = ($urandom_range(0, 9) == 0);
      low_bits  = iab_like ? 12 : w - 8;
      fill      = rand64();
      top       = iab_like ? {IAB_OUI, 12'h000} : (KEY_W'(fill[5:0]) << (w - 6));
      half      = longint'(1) << (low_bits - 1);
      step_max  = int'(half / longint'(e - b + 1));
      if (step_max < 1) step_max = 1;
      lo = $urandom_range(0, int'(half) - 1);
      for (int a = b; a < e; a++) begin
        fill = rand64();
        key  = scrambled ? (fill[KEY_W-1:0] & ((36'd1 << w) - 36'd1))
                         : (top | KEY_W'(lo));
        send_word(CMD_WRITE, ENTRY_IDX_W'(a), key, fill[63:16]);
        lo += $urandom_range(1, step_max);
      end
    end
  endtask

  // Result side: checks each word taken and stalls at random, with a long
  // hold whenever the stimulus asks for one.
  initial begin
    int gap_left;
    int hold_left;
    int run_left;
    int holds_seen;
    bit steady;
    gap_left   = 0;
    hold_left  = 0;
    run_left   = 0;
    holds_seen = 0;
    steady     = 1'b0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata);
      if (holds_seen != hold_requests) begin
        holds_seen = hold_requests;
        hold_left  = RX_HOLD_CYCLES;
      end
      if (run_left == 0) begin
        steady   = ($urandom_range(0, 3) == 0);
        run_left = $urandom_range(50, 300);
      end
      run_left--;
      if (hold_left > 0) hold_left--;
      else if (gap_left > 0) gap_left--;
      else if (!steady && $urandom_range(0, 3) == 0) gap_left = idle_len();
      m_axis_tready <= (hold_left == 0 && gap_left == 0);
    end
  end

  // Ends the run when no word moves anywhere for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
        quiet = 0;
      else
        quiet++;
    end
    $display("tb_mac_vendor_prefix_lookup: FAIL");
    $finish;
  end

  // Stimulus: directed lookups, then phases of layout, load and lookups.
  initial begin
    int               phase;
    int               n;
    int               sel;
    int               r;
    int               a;
    int               w;
    int               live [$];
    logic [63:0]      fill;
    logic [MAC_W-1:0] mac;

    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= '0;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= CMD_WRITE;
    words_sent    = 0;
    hold_requests = 0;
    tx_run        = 0;
    tx_steady     = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // With the reset bounds every region is empty.
    for (int i = 0; i < 5; i++) begin
      fill = rand64();
      send_word(CMD_LOOKUP, fill[15:0], fill[51:16], RESET_PROBES[i]);
    end
    drain();

    // Directed layout: two keys per region, packed from address zero.
    bnd = '{0, 2, 4, 6, 8, 10};
    apply_bounds(1'b1);
    for (int i = 0; i < 10; i++) begin
      fill = rand64();
      send_word(CMD_WRITE, ENTRY_IDX_W'(i), SEED_KEYS[i], fill[47:0]);
    end
    for (int i = 0; i < 12; i++) begin
      fill = rand64();
      send_word(CMD_LOOKUP, fill[15:0], fill[51:16], LAYOUT_PROBES[i]);
    end
    drain();

    phase = 0;
    while (words_sent < TOTAL_WORDS) begin
      plan_layout(phase);
      apply_bounds(phase % 3 == 0);
      load_regions();
      live.delete();
      for (int i = 0; i < NUM_REGIONS; i++) begin
        if (bnd[i] < bnd[i + 1] && bnd[i] < KEY_DEPTH) live.push_back(i);
      end
      n = $urandom_range(40, 80);
      for (int i = 0; i < n; i++) begin
        if (phase == 2 && i == 5) hold_requests++;
        if (phase % 4 == 1 && i == n / 2) drain();
        fill = rand64();
        sel  = $urandom_range(0, 99);
        if (sel < 8) begin
          // Stray key write anywhere in memory.
          send_word(CMD_WRITE, fill[15:0], fill[51:16], fill[63:16]);
        end else if (sel < 80 && live.size() != 0) begin
          // Address built from a stored key; some get one prefix bit flipped.
          r    = live[$urandom_range(0, live.size() - 1)];
          a    = $urandom_range(bnd[r], ((bnd[r + 1] > KEY_DEPTH) ? KEY_DEPTH : bnd[r + 1]) - 1);
          w    = PREFIX_BITS[r];
          mac  = ({12'd0, sb.key_mirror[a]} << (MAC_W - w)) |
                 (fill[47:0] & ((48'd1 << (MAC_W - w)) - 48'd1));
          if (sel >= 70) mac[MAC_W - 1 - $urandom_range(0, w - 1)] ^= 1'b1;
          send_word(CMD_LOOKUP, fill[63:48], fill[51:16], mac);
        end else begin
          send_word(CMD_LOOKUP, fill[63:48], fill[51:16], fill[47:0]);
        end
      end
      drain();
      phase++;
    end

    if (sb.failures == 0 && sb.pending_matches.size() == 0)
      $display("tb_mac_vendor_prefix_lookup: PASS");
    else
      $display("tb_mac_vendor_prefix_lookup: FAIL");
    $finish;
  end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/mvpl_pkg.sv
hw/rtl/mvpl_key_mem.sv
hw/rtl/mvpl_search.sv
hw/rtl/mac_vendor_prefix_lookup.sv
test/tb_mac_vendor_prefix_lookup.sv
